// ===== rtl/core/fbsu_pkg.sv =====
`default_nettype none
package fbsu_pkg;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] raw_word;
   } req_word_type;

   typedef struct packed {
      logic [15:0] sample;
      logic [11:0] channel;
      logic        spectrum_end;
      logic        run_last;
   } rsp_word_type;

   // command to the shared float unit: div=0 is a - b, div=1 is a / b
   typedef struct packed {
      logic start;
      logic div;
   } fpu_cmd_type;

   localparam logic [1:0] MODE_CONVERT = 2'd0;
   localparam logic [1:0] MODE_SCAN    = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   localparam logic [2:0] BITS_1   = 3'd0;
   localparam logic [2:0] BITS_2   = 3'd1;
   localparam logic [2:0] BITS_4   = 3'd2;
   localparam logic [2:0] BITS_8   = 3'd3;
   localparam logic [2:0] BITS_16  = 3'd4;
   localparam logic [2:0] BITS_F32 = 3'd5;

   localparam logic [0:0] REG_BITS_CODE     = 1'd0;
   localparam logic [0:0] REG_CHANNEL_COUNT = 1'd1;

   localparam logic [2:0]  BITS_CODE_INIT     = BITS_8;
   localparam logic [12:0] CHANNEL_COUNT_INIT = 13'd4096;

   localparam logic [31:0] RANGE_LOW_INIT  = 32'h501502F9;  // 1e10
   localparam logic [31:0] RANGE_HIGH_INIT = 32'hD01502F9;  // -1e10
   localparam logic [31:0] F32_65535       = 32'h477FFF00;
   localparam logic [31:0] F32_QNAN        = 32'h7FC00000;

endpackage
`default_nettype wire

// ===== rtl/core/fbsu_fpu.sv =====
`default_nettype none
module fbsu_fpu (
   input  logic                   clock,
   input  logic                   reset,
   input  fbsu_pkg::fpu_cmd_type  cmd,
   input  logic [31:0]            op_a,
   input  logic [31:0]            op_b,
   output logic                   done,
   output logic [31:0]            result
);

   typedef enum logic [2:0] {
      F_IDLE, F_PREP, F_ALIGN, F_ADD, F_DIV, F_NORM, F_ROUND
   } fstate_type;

   fstate_type         state_ff;
   logic               sa_ff, sb_ff, sr_ff;
   logic signed [10:0] ea_ff, eb_ff, er_ff;
   logic [27:0]        ma_ff, mb_ff, mr_ff, q_ff;
   logic [24:0]        rem_ff;
   logic [4:0]         cnt_ff;
   logic [31:0]        res_ff;
   logic               done_ff;

   logic [7:0]         a_exp, b_exp;
   logic [22:0]        a_frac, b_frac;
   logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, b_sign;
   logic signed [10:0] a_e, b_e, diff_ab;
   logic [27:0]        add_m;
   logic               add_s;
   logic               div_ge;
   logic [24:0]        rem_keep;
   logic               rnd_inc;
   logic [7:0]         rnd_e;
   logic [30:0]        rnd_bits;

   // shift right one place, folding the lost bit into sticky
   function automatic logic [27:0] shr1(input logic [27:0] m);
      return {1'b0, m[27:2], m[1] | m[0]};
   endfunction

   always_comb begin
      a_exp  = op_a[30:23];
      b_exp  = op_b[30:23];
      a_frac = op_a[22:0];
      b_frac = op_b[22:0];
      a_nan  = (&a_exp) && (|a_frac);
      b_nan  = (&b_exp) && (|b_frac);
      a_inf  = (&a_exp) && !(|a_frac);
      b_inf  = (&b_exp) && !(|b_frac);
      a_zero = (op_a[30:0] == 31'd0);
      b_zero = (op_b[30:0] == 31'd0);
      b_sign = cmd.div ? op_b[31] : !op_b[31];
      a_e    = (a_exp == 8'd0) ? 11'sd1 : $signed({3'b000, a_exp});
      b_e    = (b_exp == 8'd0) ? 11'sd1 : $signed({3'b000, b_exp});
      diff_ab = ea_ff - eb_ff;

      if (sa_ff == sb_ff) begin
         add_m = ma_ff + mb_ff;
         add_s = sa_ff;
      end else if (ma_ff >= mb_ff) begin
         add_m = ma_ff - mb_ff;
         add_s = sa_ff;
      end else begin
         add_m = mb_ff - ma_ff;
         add_s = sb_ff;
      end

      div_ge   = (rem_ff >= {1'b0, mb_ff[23:0]});
      rem_keep = div_ge ? (rem_ff - {1'b0, mb_ff[23:0]}) : rem_ff;

      rnd_inc  = mr_ff[2] & (mr_ff[1] | mr_ff[0] | mr_ff[3]);
      rnd_e    = mr_ff[26] ? er_ff[7:0] : 8'd0;
      rnd_bits = {rnd_e, mr_ff[25:3]} + 31'(rnd_inc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            F_IDLE: begin
               if (cmd.start) begin
                  sa_ff <= op_a[31];
                  sb_ff <= b_sign;
                  ea_ff <= a_e;
                  eb_ff <= b_e;
                  if (!cmd.div) begin
                     ma_ff <= {1'b0, |a_exp, a_frac, 3'b000};
                     mb_ff <= {1'b0, |b_exp, b_frac, 3'b000};
                     if (a_nan || b_nan || (a_inf && b_inf && (op_a[31] != b_sign))) begin
                        res_ff  <= fbsu_pkg::F32_QNAN;
                        done_ff <= 1'b1;
                     end else if (a_inf) begin
                        res_ff  <= {op_a[31], 8'hFF, 23'd0};
                        done_ff <= 1'b1;
                     end else if (b_inf) begin
                        res_ff  <= {b_sign, 8'hFF, 23'd0};
                        done_ff <= 1'b1;
                     end else begin
                        state_ff <= F_ALIGN;
                     end
                  end else begin
                     ma_ff <= {4'd0, |a_exp, a_frac};
                     mb_ff <= {4'd0, |b_exp, b_frac};
                     if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                        res_ff  <= fbsu_pkg::F32_QNAN;
                        done_ff <= 1'b1;
                     end else if (a_inf || b_zero) begin
                        res_ff  <= {op_a[31] ^ b_sign, 8'hFF, 23'd0};
                        done_ff <= 1'b1;
                     end else if (b_inf || a_zero) begin
                        res_ff  <= {op_a[31] ^ b_sign, 31'd0};
                        done_ff <= 1'b1;
                     end else begin
                        state_ff <= F_PREP;
                     end
                  end
               end
            end
            F_ALIGN: begin
               if (diff_ab == 11'sd0) begin
                  state_ff <= F_ADD;
               end else if (diff_ab > 11'sd0) begin
                  if (diff_ab > 11'sd27) begin
                     mb_ff <= {27'd0, |mb_ff};
                     eb_ff <= ea_ff;
                  end else begin
                     mb_ff <= shr1(mb_ff);
                     eb_ff <= eb_ff + 11'sd1;
                  end
               end else begin
                  if (diff_ab < -11'sd27) begin
                     ma_ff <= {27'd0, |ma_ff};
                     ea_ff <= eb_ff;
                  end else begin
                     ma_ff <= shr1(ma_ff);
                     ea_ff <= ea_ff + 11'sd1;
                  end
               end
            end
            F_ADD: begin
               er_ff <= ea_ff;
               mr_ff <= add_m;
               if (add_m == 28'd0) begin
                  // exact zero: negative only when both terms are negative
                  res_ff   <= {sa_ff & sb_ff, 31'd0};
                  done_ff  <= 1'b1;
                  state_ff <= F_IDLE;
               end else begin
                  sr_ff    <= add_s;
                  state_ff <= F_NORM;
               end
            end
            F_PREP: begin
               if (!ma_ff[23]) begin
                  ma_ff <= {ma_ff[26:0], 1'b0};
                  ea_ff <= ea_ff - 11'sd1;
               end else if (!mb_ff[23]) begin
                  mb_ff <= {mb_ff[26:0], 1'b0};
                  eb_ff <= eb_ff - 11'sd1;
               end else begin
                  rem_ff   <= {1'b0, ma_ff[23:0]};
                  q_ff     <= 28'd0;
                  cnt_ff   <= 5'd0;
                  er_ff    <= ea_ff - eb_ff + 11'sd126;
                  sr_ff    <= sa_ff ^ sb_ff;
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               rem_ff <= {rem_keep[23:0], 1'b0};
               q_ff   <= {q_ff[26:0], div_ge};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd27) begin
                  mr_ff    <= {q_ff[26:0], div_ge | (rem_keep != 25'd0)};
                  state_ff <= F_NORM;
               end
            end
            F_NORM: begin
               if (mr_ff[27] || (er_ff < 11'sd1)) begin
                  mr_ff <= shr1(mr_ff);
                  er_ff <= er_ff + 11'sd1;
               end else if (!mr_ff[26] && (er_ff > 11'sd1)) begin
                  mr_ff <= {mr_ff[26:0], 1'b0};
                  er_ff <= er_ff - 11'sd1;
               end else begin
                  state_ff <= F_ROUND;
               end
            end
            F_ROUND: begin
               if (er_ff >= 11'sd255) begin
                  res_ff <= {sr_ff, 8'hFF, 23'd0};
               end else begin
                  res_ff <= {sr_ff, rnd_bits};
               end
               done_ff  <= 1'b1;
               state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

// ===== rtl/core/filterbank_sample_unpacker.sv =====
// Filterbank sample unpacker.
// req channel: one word {mode, raw_word} per handshake (valid high, stall low).
// rsp channel: {sample, channel, spectrum_end, run_last}, held while rsp_stall.
// csr port: csr_wr_en with csr_index 0 (bits_code) or 1 (channel_count);
// write only while idle.
// Convert words in 1/2/4/8/16-bit modes give 8/4/2/1/1 results; after
// accept the word moves to S_EMIT, which loads them into the output register
// one per cycle while rsp_stall is low or no result is held.
// Scan, clear and ignored words are handled on accept without leaving idle.
// Float convert runs up to four passes through the shared float unit (sub,
// div, sub, div); a zero bin width gives a zero sample after the first two.
// req_stall is high whenever a word is in progress. A stalled result holds
// the last sample in the output register and freezes the sequence.
// Reset: bits_code=3, channel_count=4096, range low/high = +/-1e10,
// channel counter 0, no result pending.
`default_nettype none
module filterbank_sample_unpacker #(
   parameter int MAX_CHANNELS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  fbsu_pkg::req_word_type       req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output fbsu_pkg::rsp_word_type       rsp_data,
   input  logic                         csr_wr_en,
   input  logic [0:0]                   csr_index,
   input  logic [12:0]                  csr_wdata
);

   localparam int IDX_W = $clog2(MAX_CHANNELS);

   typedef enum logic [2:0] {
      S_IDLE, S_EMIT, S_SPAN, S_BIN, S_DIFF, S_QUOT
   } state_type;

   state_type               state_ff;
   logic [2:0]              bits_code_ff;
   logic [12:0]             chan_count_ff;
   logic [31:0]             range_low_ff, range_high_ff;
   logic [IDX_W-1:0]        chan_idx_ff;
   logic [31:0]             word_ff, bin_ff;
   logic [15:0]             fval_ff;
   logic [2:0]              step_ff, last_ff;
   logic                    rsp_valid_ff;
   fbsu_pkg::rsp_word_type  rsp_word_ff;
   fbsu_pkg::fpu_cmd_type   fpu_cmd_ff;
   logic [31:0]             fpu_a_ff, fpu_b_ff;

   logic                    fpu_done;
   logic [31:0]             fpu_res;
   logic                    accept, out_free, rsp_load, spec_end;
   logic [31:0]             eff_n, idx_p1;
   logic [7:0]              byte_b;
   logic [15:0]             emit_sample;
   fbsu_pkg::rsp_word_type  rsp_in;

   function automatic logic fgt(input logic [31:0] a, input logic [31:0] b);
      logic na, nb;
      na = (&a[30:23]) && (|a[22:0]);
      nb = (&b[30:23]) && (|b[22:0]);
      if (na || nb) return 1'b0;
      if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
      if (a[31] != b[31]) return b[31];
      if (!a[31]) return a[30:0] > b[30:0];
      return a[30:0] < b[30:0];
   endfunction

   // truncate a float quotient to 0..65535
   function automatic logic [15:0] to_sample(input logic [31:0] q);
      logic [23:0] m;
      logic [7:0]  sh;
      logic [23:0] r;
      m  = {1'b1, q[22:0]};
      sh = 8'd150 - q[30:23];
      r  = m >> sh[4:0];
      if (((&q[30:23]) && (|q[22:0])) || q[31] || (q[30:0] == 31'd0)) return 16'd0;
      if (q[30:0] >= fbsu_pkg::F32_65535[30:0]) return 16'hFFFF;
      if (q[30:23] < 8'd127) return 16'd0;
      return r[15:0];
   endfunction

   fbsu_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (fpu_cmd_ff),
      .op_a   (fpu_a_ff),
      .op_b   (fpu_b_ff),
      .done   (fpu_done),
      .result (fpu_res)
   );

   always_comb begin
      req_stall = (state_ff != S_IDLE);
      accept    = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      rsp_load  = (state_ff == S_EMIT) && out_free;

      if (chan_count_ff == 13'd0) begin
         eff_n = 32'd1;
      end else if (32'(chan_count_ff) > 32'(MAX_CHANNELS)) begin
         eff_n = 32'(MAX_CHANNELS);
      end else begin
         eff_n = 32'(chan_count_ff);
      end
      idx_p1   = 32'(chan_idx_ff) + 32'd1;
      spec_end = (idx_p1 >= eff_n);

      byte_b = word_ff[7:0];
      case (bits_code_ff)
         fbsu_pkg::BITS_1:   emit_sample = 16'(byte_b[step_ff]);
         fbsu_pkg::BITS_2:   emit_sample = 16'(byte_b[{~step_ff[1:0], 1'b0} +: 2]);
         fbsu_pkg::BITS_4:   emit_sample = 16'(byte_b[{~step_ff[0], 2'b00} +: 4]);
         fbsu_pkg::BITS_8:   emit_sample = 16'(byte_b);
         fbsu_pkg::BITS_16:  emit_sample = word_ff[15:0];
         fbsu_pkg::BITS_F32: emit_sample = fval_ff;
         default:            emit_sample = 16'd0;
      endcase

      rsp_in.sample       = emit_sample;
      rsp_in.channel      = 12'(chan_idx_ff);
      rsp_in.spectrum_end = spec_end;
      rsp_in.run_last     = (step_ff == last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         bits_code_ff     <= fbsu_pkg::BITS_CODE_INIT;
         chan_count_ff    <= fbsu_pkg::CHANNEL_COUNT_INIT;
         range_low_ff     <= fbsu_pkg::RANGE_LOW_INIT;
         range_high_ff    <= fbsu_pkg::RANGE_HIGH_INIT;
         chan_idx_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
         fpu_cmd_ff       <= '0;
      end else begin
         fpu_cmd_ff.start <= 1'b0;

         if (csr_wr_en) begin
            case (csr_index)
               fbsu_pkg::REG_BITS_CODE:     bits_code_ff  <= csr_wdata[2:0];
               fbsu_pkg::REG_CHANNEL_COUNT: chan_count_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (out_free) begin
            rsp_valid_ff <= rsp_load;
         end
         if (rsp_load) begin
            rsp_word_ff <= rsp_in;
            chan_idx_ff <= spec_end ? '0 : IDX_W'(idx_p1);
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  word_ff <= req_data.raw_word;
                  step_ff <= 3'd0;
                  case (req_data.mode)
                     fbsu_pkg::MODE_CLEAR: begin
                        range_low_ff  <= fbsu_pkg::RANGE_LOW_INIT;
                        range_high_ff <= fbsu_pkg::RANGE_HIGH_INIT;
                        chan_idx_ff   <= '0;
                     end
                     fbsu_pkg::MODE_SCAN: begin
                        if (bits_code_ff == fbsu_pkg::BITS_F32) begin
                           if (fgt(req_data.raw_word, range_high_ff)) begin
                              range_high_ff <= req_data.raw_word;
                           end
                           if (fgt(range_low_ff, req_data.raw_word)) begin
                              range_low_ff <= req_data.raw_word;
                           end
                        end
                     end
                     fbsu_pkg::MODE_CONVERT: begin
                        case (bits_code_ff)
                           fbsu_pkg::BITS_1: begin
                              last_ff  <= 3'd7;
                              state_ff <= S_EMIT;
                           end
                           fbsu_pkg::BITS_2: begin
                              last_ff  <= 3'd3;
                              state_ff <= S_EMIT;
                           end
                           fbsu_pkg::BITS_4: begin
                              last_ff  <= 3'd1;
                              state_ff <= S_EMIT;
                           end
                           fbsu_pkg::BITS_8, fbsu_pkg::BITS_16: begin
                              last_ff  <= 3'd0;
                              state_ff <= S_EMIT;
                           end
                           fbsu_pkg::BITS_F32: begin
                              last_ff          <= 3'd0;
                              fpu_cmd_ff.start <= 1'b1;
                              fpu_cmd_ff.div   <= 1'b0;
                              fpu_a_ff         <= range_high_ff;
                              fpu_b_ff         <= range_low_ff;
                              state_ff         <= S_SPAN;
                           end
                           default: ;
                        endcase
                     end
                     default: ;
                  endcase
               end
            end
            S_EMIT: begin
               if (rsp_load) begin
                  if (step_ff == last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     step_ff <= step_ff + 3'd1;
                  end
               end
            end
            S_SPAN: begin
               if (fpu_done) begin
                  fpu_cmd_ff.start <= 1'b1;
                  fpu_cmd_ff.div   <= 1'b1;
                  fpu_a_ff         <= fpu_res;
                  fpu_b_ff         <= fbsu_pkg::F32_65535;
                  state_ff         <= S_BIN;
               end
            end
            S_BIN: begin
               if (fpu_done) begin
                  bin_ff <= fpu_res;
                  if (fpu_res[30:0] == 31'd0) begin
                     // zero bin width: sample is zero
                     fval_ff  <= 16'd0;
                     state_ff <= S_EMIT;
                  end else begin
                     fpu_cmd_ff.start <= 1'b1;
                     fpu_cmd_ff.div   <= 1'b0;
                     fpu_a_ff         <= word_ff;
                     fpu_b_ff         <= range_low_ff;
                     state_ff         <= S_DIFF;
                  end
               end
            end
            S_DIFF: begin
               if (fpu_done) begin
                  fpu_cmd_ff.start <= 1'b1;
                  fpu_cmd_ff.div   <= 1'b1;
                  fpu_a_ff         <= fpu_res;
                  fpu_b_ff         <= bin_ff;
                  state_ff         <= S_QUOT;
               end
            end
            S_QUOT: begin
               if (fpu_done) begin
                  fval_ff  <= to_sample(fpu_res);
                  state_ff <= S_EMIT;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   a_end_wraps: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_in.spectrum_end) |=> (chan_idx_ff == '0))
      else $error("channel counter did not wrap after spectrum end");

   a_fpu_done_busy: assert property (@(posedge clock) disable iff (reset)
      fpu_done |-> ((state_ff == S_SPAN) || (state_ff == S_BIN) ||
                    (state_ff == S_DIFF) || (state_ff == S_QUOT)))
      else $error("float unit finished outside a float step");

   a_convert_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.mode == fbsu_pkg::MODE_CONVERT) &&
       (bits_code_ff <= fbsu_pkg::BITS_F32)) |=> (state_ff != S_IDLE))
      else $error("convert word produced no work");

endmodule
`default_nettype wire

// ===== verif/filterbank_sample_unpacker_tb.sv =====
`default_nettype none
module filterbank_sample_unpacker_tb;
   import fbsu_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [2:0] BITS_UNUSED6 = 3'd6;
   localparam logic [2:0] BITS_UNUSED7 = 3'd7;
   localparam int MAX_CHANNELS = 4096;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int LONG_HOLD = 300;

   class fb_scoreboard;
      rsp_word_type sample_q[$];
      logic [2:0] bits_code;
      logic [12:0] chan_count;
      logic [31:0] range_lo;
      logic [31:0] range_hi;
      logic [11:0] chan_idx;
      int errors;

      function new();
         bits_code = BITS_CODE_INIT;
         chan_count = CHANNEL_COUNT_INIT;
         range_lo = RANGE_LOW_INIT;
         range_hi = RANGE_HIGH_INIT;
         chan_idx = '0;
         errors = 0;
      endfunction

      function void set_reg(logic [0:0] idx, logic [12:0] value);
         if (idx == REG_BITS_CODE) begin
            bits_code = value[2:0];
         end else begin
            chan_count = value;
         end
      endfunction

      // single to double, exact
      static function real f2r(logic [31:0] f);
         real v;
         if (f[30:23] == 8'hff) begin
            return $bitstoreal({f[31], 11'h7ff, f[22:0], 29'd0});
         end
         if (f[30:23] == 8'h00) begin
            v = real'(f[22:0]) * (2.0 ** (-149));
            return f[31] ? -v : v;
         end
         return $bitstoreal({f[31], 11'(f[30:23]) + 11'd896, f[22:0], 29'd0});
      endfunction

      // double to single, round to nearest even; one double op then this
      // rounding matches a native single op for add, sub and div
      static function logic [31:0] r2f(real r);
         logic [63:0] d;
         logic [63:0] sig;
         logic [63:0] mant;
         logic [63:0] rest;
         logic [63:0] half;
         int fe;
         int t;
         d = $realtobits(r);
         if (d[62:52] == 11'h7ff) begin
            return (d[51:0] != 0) ? F32_QNAN : {d[63], 8'hff, 23'd0};
         end
         if (d[62:52] == 11'd0) begin
            return {d[63], 31'd0};
         end
         sig = {11'd0, 1'b1, d[51:0]};
         fe = int'(d[62:52]) - 1023 + 127;
         t = (fe >= 1) ? 29 : 30 - fe;
         if (t > 60) begin
            return {d[63], 31'd0};
         end
         mant = sig >> t;
         rest = sig & ((64'd1 << t) - 64'd1);
         half = 64'd1 << (t - 1);
         if (rest > half || (rest == half && mant[0])) begin
            mant = mant + 64'd1;
         end
         if (fe < 1) begin
            return {d[63], mant[30:0]};
         end
         if (mant[24]) begin
            mant = mant >> 1;
            fe = fe + 1;
         end
         if (fe >= 255) begin
            return {d[63], 8'hff, 23'd0};
         end
         return {d[63], fe[7:0], mant[22:0]};
      endfunction

      function logic [15:0] scale_sample(logic [31:0] x);
         logic [31:0] span;
         logic [31:0] bin;
         logic [31:0] diff;
         logic [31:0] quot;
         real qr;
         span = r2f(f2r(range_hi) - f2r(range_lo));
         bin = r2f(f2r(span) / f2r(F32_65535));
         if (f2r(bin) == 0.0) begin
            return 16'd0;
         end
         diff = r2f(f2r(x) - f2r(range_lo));
         quot = r2f(f2r(diff) / f2r(bin));
         qr = f2r(quot);
         if (!(qr > 0.0)) begin
            return 16'd0;
         end
         if (qr >= 65535.0) begin
            return 16'hffff;
         end
         return 16'($rtoi(qr));
      endfunction

      function void push_sample(logic [15:0] s, logic last);
         int n;
         logic fin;
         n = (chan_count == 0) ? 1 : ((chan_count > MAX_CHANNELS) ? MAX_CHANNELS
                                                                  : int'(chan_count));
         fin = (int'(chan_idx) + 1 >= n);
         sample_q.push_back('{sample: s, channel: chan_idx, spectrum_end: fin,
                              run_last: last});
         chan_idx = fin ? 12'd0 : chan_idx + 12'd1;
      endfunction

      function void note_word(req_word_type w);
         logic [7:0] b;
         real x;
         b = w.raw_word[7:0];
         if (w.mode == MODE_CLEAR) begin
            range_lo = RANGE_LOW_INIT;
            range_hi = RANGE_HIGH_INIT;
            chan_idx = '0;
         end else if (w.mode == MODE_SCAN) begin
            if (bits_code == BITS_F32) begin
               x = f2r(w.raw_word);
               if (x > f2r(range_hi)) range_hi = w.raw_word;
               if (x < f2r(range_lo)) range_lo = w.raw_word;
            end
         end else if (w.mode == MODE_CONVERT) begin
            case (bits_code)
               BITS_1: begin
                  for (int i = 0; i < 8; i++) push_sample(16'(b[i]), i == 7);
               end
               BITS_2: begin
                  for (int i = 0; i < 4; i++) push_sample(16'((b >> (6 - 2 * i)) & 8'h03),
                                                         i == 3);
               end
               BITS_4: begin
                  push_sample(16'(b[7:4]), 1'b0);
                  push_sample(16'(b[3:0]), 1'b1);
               end
               BITS_8: push_sample(16'(b), 1'b1);
               BITS_16: push_sample(w.raw_word[15:0], 1'b1);
               BITS_F32: push_sample(scale_sample(w.raw_word), 1'b1);
               default: ;
            endcase
         end
      endfunction

      function void check(rsp_word_type got);
         rsp_word_type want;
         if (sample_q.size() == 0) begin
            $error("unexpected word: sample %0d channel %0d", got.sample, got.channel);
            errors++;
            return;
         end
         want = sample_q.pop_front();
         if (got.sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, got.sample);
            errors++;
         end
         if (got.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, got.channel);
            errors++;
         end
         if (got.spectrum_end !== want.spectrum_end) begin
            $error("spectrum_end: expected %0d, got %0d", want.spectrum_end,
                   got.spectrum_end);
            errors++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
            errors++;
         end
      endfunction

      function int pending();
         return sample_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [0:0] csr_index = '0;
   logic [12:0] csr_wdata = '0;

   fb_scoreboard sb = new();
   int gap_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_done = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   filterbank_sample_unpacker uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side; a long hold is counted here
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_req != hold_done) begin
         hold_done = hold_req;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] mode, logic [31:0] raw);
      req_word_type w;
      w.mode = mode;
      w.raw_word = raw;
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [12:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   function automatic logic [31:0] rand_float();
      logic [31:0] specials[8] = '{32'h0, 32'h80000000, 32'h7f800000, 32'hff800000,
                                   32'h7fc00001, 32'h00000001, 32'h007fffff, 32'hffffffff};
      int r;
      r = $urandom_range(99);
      if (r < 10) return specials[$urandom_range(7)];
      if (r < 25) return $urandom;
      return {1'($urandom), 8'(120 + $urandom_range(20)), 23'($urandom)};
   endfunction

   task automatic random_word(logic [2:0] bits);
      int r;
      r = $urandom_range(99);
      if (r < 3) begin
         send_word(MODE_CLEAR, $urandom);
      end else if (r < 6) begin
         send_word(MODE_UNUSED, $urandom);
      end else if (bits == BITS_F32) begin
         if (r < 40) send_word(MODE_SCAN, rand_float());
         else send_word(MODE_CONVERT, rand_float());
      end else if (r < 12) begin
         send_word(MODE_SCAN, $urandom);
      end else begin
         send_word(MODE_CONVERT, $urandom);
      end
   endtask

   initial begin
      static int bits_tab[13] = '{0, 1, 2, 3, 4, 5, 0, 1, 6, 2, 5, 4, 3};
      static int count_tab[13] = '{3, 5, 1, 4096, 8, 7, 0, 8191, 2, 4095, 1, 3, 2};
      static int items_tab[13] = '{30, 30, 25, 20, 30, 25, 25, 20, 5, 25, 20, 25, 25};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 8-bit, full spectrum
      send_word(MODE_CONVERT, 32'h0);
      send_word(MODE_CONVERT, 32'hffffffff);
      send_word(MODE_UNUSED, 32'hffffffff);
      send_word(MODE_SCAN, 32'h12);
      send_word(MODE_CLEAR, 32'h0);
      write_reg(REG_BITS_CODE, 13'(BITS_1));
      write_reg(REG_CHANNEL_COUNT, 13'd3);
      send_word(MODE_CONVERT, 32'ha5);
      send_word(MODE_CONVERT, 32'h5a);
      write_reg(REG_BITS_CODE, 13'(BITS_2));
      write_reg(REG_CHANNEL_COUNT, 13'd0);
      send_word(MODE_CONVERT, 32'h1b);
      send_word(MODE_CONVERT, 32'he4);
      write_reg(REG_BITS_CODE, 13'(BITS_4));
      write_reg(REG_CHANNEL_COUNT, 13'd8191);
      send_word(MODE_CONVERT, 32'hf0);
      send_word(MODE_CONVERT, 32'h0f);
      write_reg(REG_BITS_CODE, 13'(BITS_16));
      send_word(MODE_CONVERT, 32'hffff0000);
      send_word(MODE_CONVERT, 32'h0000ffff);
      write_reg(REG_BITS_CODE, 13'(BITS_UNUSED7));
      send_word(MODE_CONVERT, 32'h1);
      write_reg(REG_BITS_CODE, 13'(BITS_F32));
      send_word(MODE_CONVERT, 32'h3f800000);   // inverted reset range
      send_word(MODE_SCAN, 32'h7fc00000);      // NaN never updates
      send_word(MODE_SCAN, 32'h3f800000);
      send_word(MODE_CONVERT, 32'h3f800000);   // zero range
      send_word(MODE_SCAN, 32'h40000000);
      send_word(MODE_SCAN, 32'hbf800000);
      send_word(MODE_CONVERT, 32'h0);
      send_word(MODE_CONVERT, 32'h7f800000);
      send_word(MODE_CONVERT, 32'h7fc00000);
      send_word(MODE_CONVERT, 32'hff800000);
      send_word(MODE_CONVERT, 32'h40400000);

      // no clear between phases but at the start of float phases, so lowered counts hit mid-spectrum
      for (int p = 0; p < 13; p++) begin
         write_reg(REG_BITS_CODE, 13'(bits_tab[p]));
         write_reg(REG_CHANNEL_COUNT, 13'(count_tab[p]));
         case (p % 4)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 59; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 59; end
            default: begin gap_pct = 24; stall_pct = 24; end
         endcase
         if (p == 0) hold_req++;
         if (bits_tab[p] == BITS_F32) send_word(MODE_CLEAR, 32'h0);
         for (int i = 0; i < items_tab[p]; i++) random_word(3'(bits_tab[p]));
      end
      write_reg(REG_BITS_CODE, 13'(BITS_UNUSED6));
      send_word(MODE_CONVERT, $urandom);

      drain();
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/fbsu_pkg.sv
rtl/core/fbsu_fpu.sv
rtl/core/filterbank_sample_unpacker.sv
verif/filterbank_sample_unpacker_tb.sv
